>>> rtl/tma_pkg.sv
package tma_pkg;

	// default sizes of the tile store
	localparam int MAX_TILES_DEF = 4096;
	localparam int TILE_BITS_DEF = 8;

	// configuration register indexes
	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_MODE   = 2'd2;

	// item operations
	localparam logic [1:0] OP_READ      = 2'd0;
	localparam logic [1:0] OP_WRITE     = 2'd1;
	localparam logic [1:0] OP_WRITE_NBR = 2'd2;
	localparam logic [1:0] OP_MAP       = 2'd3;

	// autotile modes
	localparam logic [1:0] MODE_OFF = 2'd0;
	localparam logic [1:0] MODE_ALT = 2'd2;

	// neighbor read slots, in read order
	localparam logic [3:0] NB_CTR = 4'd0;
	localparam logic [3:0] NB_UP  = 4'd1;
	localparam logic [3:0] NB_RT  = 4'd2;
	localparam logic [3:0] NB_DN  = 4'd3;
	localparam logic [3:0] NB_LF  = 4'd4;
	localparam logic [3:0] NB_DL  = 4'd5;
	localparam logic [3:0] NB_UL  = 4'd6;
	localparam logic [3:0] NB_UR  = 4'd7;
	localparam logic [3:0] NB_DR  = 4'd8;

	// which orthogonal neighbors lie inside the map
	typedef struct packed {
		logic up;
		logic rt;
		logic dn;
		logic lf;
	} nb_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_WRITE,
		ST_CELL,
		ST_RD,
		ST_RDL,
		ST_WB,
		ST_RES,
		ST_DONE
	} state_t;

endpackage

>>> rtl/tma_ram.sv
module tma_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/tma_cell.sv
module tma_cell #(
	parameter int TILE_BITS = tma_pkg::TILE_BITS_DEF
) (
	input  logic               alt,
	input  tma_pkg::nb_t       nb,
	input  logic [8:0]         nz,
	output logic               wr,
	output logic [TILE_BITS-1:0] code
);

	logic [3:0] m;
	logic [3:0] v;

	// four-neighbor mask, border counts as filled
	always_comb begin
		m[0] = !nb.up || nz[tma_pkg::NB_UP];
		m[1] = !nb.rt || nz[tma_pkg::NB_RT];
		m[2] = !nb.dn || nz[tma_pkg::NB_DN];
		m[3] = !nb.lf || nz[tma_pkg::NB_LF];
	end

	// interior corners: later diagonal wins
	always_comb begin
		v = m;
		if (alt && m == 4'hF) begin
			if (nb.lf && nb.dn && !nz[tma_pkg::NB_DL]) v = 4'd1;
			if (nb.lf && nb.up && !nz[tma_pkg::NB_UL]) v = 4'd2;
			if (nb.rt && nb.up && !nz[tma_pkg::NB_UR]) v = 4'd4;
			if (nb.rt && nb.dn && !nz[tma_pkg::NB_DR]) v = 4'd8;
		end
	end

	assign wr   = nz[tma_pkg::NB_CTR];
	assign code = TILE_BITS'({1'b0, v} + 5'd1);

endmodule

>>> rtl/tile_map_autotile_core.sv
// Tile map with four-neighbor bitmask autotiling.
// Items: raise start with op, x_pos, y_pos, tile_in while busy is low; the
// item is taken at that edge. Op 0 reads, 1 writes raw, 2 writes and
// re-autotiles the 3x3 neighborhood, 3 autotiles the whole map.
// Each item gives one result: done is high for exactly one cycle with
// tile_out and ok; the receiver cannot stall, results are never held.
// Ops 2 and 3 autotile only when mode is not 0. A read or rejected item
// goes through check, result and done; a raw write adds a write step.
// Every autotiled cell goes through index setup, nine reads from the
// single read port of the tile store, a wait for the last read and
// write-back; op 2 autotiles up to nine cells, op 3 every map cell.
// One item is in work at a time; busy stays high until its done cycle and
// the next item can be taken in the cycle after done.
// Configuration: cfg_we writes cfg_wdata to register cfg_idx (0 width,
// 1 height, 2 mode) at any edge; write only while the block is idle.
// Reset: registers take width 64, height 64, mode 0, and a clearing pass
// writes zero to every store entry, one per cycle, with busy high, before
// the first item is taken.
module tile_map_autotile_core #(
	parameter int MAX_TILES = tma_pkg::MAX_TILES_DEF,
	parameter int TILE_BITS = tma_pkg::TILE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  op,
	input  logic [11:0] x_pos,
	input  logic [11:0] y_pos,
	input  logic [7:0]  tile_in,
	output logic        done,
	output logic [7:0]  tile_out,
	output logic        ok,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [12:0] cfg_wdata
);

	localparam int AW = $clog2(MAX_TILES);
	localparam logic [31:0] MAXV = 32'(MAX_TILES);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TILES - 1);

	tma_pkg::state_t state_q, state_d;

	logic [12:0] w_q, h_q;
	logic [1:0]  mode_q;
	logic [1:0]  op_q;
	logic [11:0] x_q, y_q;
	logic [7:0]  tin_q;
	logic        inside_q;
	logic [AW-1:0] item_idx_q, idx_q, clr_q;
	logic [11:0] r_q, c_q;
	logic        last_q, full_q;
	logic [3:0]  k_q;
	logic [8:0]  nz_q;

	logic        ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [TILE_BITS-1:0] ram_wdata, ram_rdata;

	logic        w_ok, rows_nz, inside_c;
	logic [25:0] fit_p;
	logic [24:0] item_p, cell_p;
	logic [26:0] last_p;
	logic [12:0] r1, c1, y1;
	tma_pkg::nb_t nb;
	logic        cell_wr;
	logic [TILE_BITS-1:0] cell_code;
	logic [11:0] c0, cend;
	logic [12:0] r_end;
	logic        seq_end;
	logic [31:0] idx32, w32, nb_addr;

	// map geometry: rows = min(height, MAX_TILES / width) without a divider
	always_comb begin
		w_ok     = (w_q != 13'd0) && (32'(w_q) <= MAXV);
		rows_nz  = w_ok && (h_q != 13'd0);
		y1       = {1'b0, y_q} + 13'd1;
		fit_p    = y1 * w_q;
		inside_c = rows_nz && ({1'b0, x_q} < w_q) && ({1'b0, y_q} < h_q) &&
			(32'(fit_p) <= MAXV);
		item_p   = y_q * w_q + 25'(x_q);
		cell_p   = r_q * w_q + 25'(c_q);
		r1       = {1'b0, r_q} + 13'd1;
		last_p   = ({1'b0, r_q} + 14'd2) * w_q;
		c1       = {1'b0, c_q} + 13'd1;
	end

	// neighborhood bounds for op 2, in-map neighbor flags and end of the cell walk
	always_comb begin
		c0    = (x_q == 12'd0) ? 12'd0 : x_q - 12'd1;
		cend  = (({1'b0, x_q} + 13'd1) < w_q) ? x_q + 12'd1 : x_q;
		r_end = {1'b0, y_q} + 13'd1;
		nb.up = r_q != 12'd0;
		nb.lf = c_q != 12'd0;
		nb.rt = c1 < w_q;
		nb.dn = !last_q;
		if (full_q) begin
			seq_end = !nb.rt && last_q;
		end else begin
			seq_end = (c_q == cend) && (({1'b0, r_q} >= r_end) || last_q);
		end
	end

	// neighbor read address; out-of-map slots are masked by nb
	always_comb begin
		idx32 = 32'(idx_q);
		w32   = 32'(w_q);
		case (k_q)
			tma_pkg::NB_CTR: nb_addr = idx32;
			tma_pkg::NB_UP:  nb_addr = idx32 - w32;
			tma_pkg::NB_RT:  nb_addr = idx32 + 32'd1;
			tma_pkg::NB_DN:  nb_addr = idx32 + w32;
			tma_pkg::NB_LF:  nb_addr = idx32 - 32'd1;
			tma_pkg::NB_DL:  nb_addr = idx32 + w32 - 32'd1;
			tma_pkg::NB_UL:  nb_addr = idx32 - w32 - 32'd1;
			tma_pkg::NB_UR:  nb_addr = idx32 - w32 + 32'd1;
			tma_pkg::NB_DR:  nb_addr = idx32 + w32 + 32'd1;
			default:         nb_addr = idx32;
		endcase
	end

	tma_cell #(.TILE_BITS(TILE_BITS)) u_cell (
		.alt  (mode_q == tma_pkg::MODE_ALT),
		.nb   (nb),
		.nz   (nz_q),
		.wr   (cell_wr),
		.code (cell_code)
	);

	tma_ram #(.WIDTH(TILE_BITS), .DEPTH(MAX_TILES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tma_pkg::ST_CLEAR: if (clr_q == LAST_ADDR) state_d = tma_pkg::ST_IDLE;
			tma_pkg::ST_IDLE:  if (start) state_d = tma_pkg::ST_CHECK;
			tma_pkg::ST_CHECK: begin
				if (op_q == tma_pkg::OP_MAP) begin
					if (mode_q != tma_pkg::MODE_OFF && rows_nz) state_d = tma_pkg::ST_CELL;
					else state_d = tma_pkg::ST_RES;
				end else if (op_q != tma_pkg::OP_READ && inside_c) begin
					state_d = tma_pkg::ST_WRITE;
				end else begin
					state_d = tma_pkg::ST_RES;
				end
			end
			tma_pkg::ST_WRITE: begin
				if (op_q == tma_pkg::OP_WRITE_NBR && mode_q != tma_pkg::MODE_OFF)
					state_d = tma_pkg::ST_CELL;
				else
					state_d = tma_pkg::ST_RES;
			end
			tma_pkg::ST_CELL:  state_d = tma_pkg::ST_RD;
			tma_pkg::ST_RD:    if (k_q == tma_pkg::NB_DR) state_d = tma_pkg::ST_RDL;
			tma_pkg::ST_RDL:   state_d = tma_pkg::ST_WB;
			tma_pkg::ST_WB:    state_d = seq_end ? tma_pkg::ST_RES : tma_pkg::ST_CELL;
			tma_pkg::ST_RES:   state_d = tma_pkg::ST_DONE;
			tma_pkg::ST_DONE:  state_d = tma_pkg::ST_IDLE;
			default:           state_d = tma_pkg::ST_IDLE;
		endcase
	end

	// outputs and store port controls
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = cell_code;
		ram_raddr = AW'(nb_addr);
		done      = 1'b0;
		busy      = state_q != tma_pkg::ST_IDLE;
		case (state_q)
			tma_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			tma_pkg::ST_WRITE: begin
				ram_we    = 1'b1;
				ram_waddr = item_idx_q;
				ram_wdata = TILE_BITS'(tin_q);
			end
			tma_pkg::ST_WB:    ram_we = cell_wr;
			tma_pkg::ST_RES:   ram_raddr = item_idx_q;
			tma_pkg::ST_DONE:  done = 1'b1;
			default: ;
		endcase
		tile_out = inside_q ? 8'(ram_rdata) : 8'd0;
		ok       = inside_q;
	end

	// state, configuration and clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tma_pkg::ST_CLEAR;
			clr_q   <= '0;
			w_q     <= 13'd64;
			h_q     <= 13'd64;
			mode_q  <= tma_pkg::MODE_OFF;
		end else begin
			state_q <= state_d;
			if (state_q == tma_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (cfg_we) begin
				case (cfg_idx)
					tma_pkg::CFG_WIDTH:  w_q    <= cfg_wdata;
					tma_pkg::CFG_HEIGHT: h_q    <= cfg_wdata;
					tma_pkg::CFG_MODE:   mode_q <= cfg_wdata[1:0];
					default: ;
				endcase
			end
		end
	end

	// item and cell walk registers
	always_ff @(posedge clk) begin
		case (state_q)
			tma_pkg::ST_IDLE: begin
				op_q  <= op;
				x_q   <= x_pos;
				y_q   <= y_pos;
				tin_q <= tile_in;
			end
			tma_pkg::ST_CHECK: begin
				inside_q   <= inside_c;
				item_idx_q <= inside_c ? AW'(item_p) : '0;
				full_q     <= 1'b1;
				r_q        <= 12'd0;
				c_q        <= 12'd0;
			end
			tma_pkg::ST_WRITE: begin
				full_q <= 1'b0;
				r_q    <= (y_q == 12'd0) ? 12'd0 : y_q - 12'd1;
				c_q    <= c0;
			end
			tma_pkg::ST_CELL: begin
				idx_q  <= AW'(cell_p);
				last_q <= (r1 >= h_q) || (32'(last_p) > MAXV);
				k_q    <= tma_pkg::NB_CTR;
			end
			tma_pkg::ST_RD: begin
				if (k_q != tma_pkg::NB_CTR) nz_q[k_q - 4'd1] <= ram_rdata != '0;
				k_q <= k_q + 4'd1;
			end
			tma_pkg::ST_RDL: nz_q[tma_pkg::NB_DR] <= ram_rdata != '0;
			tma_pkg::ST_WB: begin
				if (full_q) begin
					if (nb.rt) begin
						c_q <= c_q + 12'd1;
					end else begin
						c_q <= 12'd0;
						r_q <= r_q + 12'd1;
					end
				end else if (c_q != cend) begin
					c_q <= c_q + 12'd1;
				end else begin
					c_q <= c0;
					r_q <= r_q + 12'd1;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> tb/sv/tb.sv
module tb;

	localparam int STORE_DEPTH = 4096;
	localparam int CYCLE_LIMIT = 5000000;

	// expected result of one item
	typedef struct {
		logic [7:0] tile;
		logic       in_map;
	} tile_result_t;

	// grid mirror: predicts every result and compares it with what arrives
	class tile_map_mirror;
		logic [7:0]   grid[STORE_DEPTH];
		int unsigned  width;
		int unsigned  height;
		logic [1:0]   mode;
		tile_result_t pending[$];
		int           errors;

		function new();
			foreach (grid[i]) grid[i] = '0;
			width  = 64;
			height = 64;
			mode   = tma_pkg::MODE_OFF;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [12:0] val);
			case (idx)
				tma_pkg::CFG_WIDTH:  width  = 32'(val);
				tma_pkg::CFG_HEIGHT: height = 32'(val);
				tma_pkg::CFG_MODE:   mode   = val[1:0];
				default: ;
			endcase
		endfunction

		function int unsigned rows();
			int unsigned fit;
			if (width == 0 || width > STORE_DEPTH) return 0;
			fit = STORE_DEPTH / width;
			return (height < fit) ? height : fit;
		endfunction

		// recompute one cell from its neighbors, in place
		function void retile(int unsigned idx, int unsigned total);
			int unsigned col;
			int unsigned m;
			if (idx >= total || grid[idx] == 0) return;
			col = idx % width;
			m = 0;
			if (idx < width || grid[idx - width] != 0) m += 1;
			if (col + 1 >= width || grid[idx + 1] != 0) m += 2;
			if (idx + width >= total || grid[idx + width] != 0) m += 4;
			if (col == 0 || grid[idx - 1] != 0) m += 8;
			// interior corners: only empty diagonals inside the map count
			if (mode == tma_pkg::MODE_ALT && m == 15) begin
				if (col > 0 && idx + width < total && grid[idx + width - 1] == 0) m = 1;
				if (col > 0 && idx >= width && grid[idx - width - 1] == 0) m = 2;
				if (col + 1 < width && idx >= width && grid[idx - width + 1] == 0) m = 4;
				if (col + 1 < width && idx + width < total && grid[idx + width + 1] == 0)
					m = 8;
			end
			grid[idx] = 8'(m + 1);
		endfunction

		function void note_item(logic [1:0] op, logic [11:0] x, logic [11:0] y,
				logic [7:0] t);
			int unsigned nrows, total, idx, r, c, rlo, clo;
			bit in_map;
			tile_result_t res;
			nrows  = rows();
			total  = width * nrows;
			in_map = nrows != 0 && x < width && y < nrows;
			idx    = in_map ? y * width + x : 0;
			if (op == tma_pkg::OP_MAP) begin
				if (mode != tma_pkg::MODE_OFF)
					for (int unsigned i = 0; i < total; i++) retile(i, total);
			end else if (op != tma_pkg::OP_READ && in_map) begin
				grid[idx] = t;
				if (op == tma_pkg::OP_WRITE_NBR && mode != tma_pkg::MODE_OFF) begin
					rlo = (y == 0) ? 0 : y - 1;
					clo = (x == 0) ? 0 : x - 1;
					for (r = rlo; r <= y + 1 && r < nrows; r++)
						for (c = clo; c <= x + 1 && c < width; c++)
							retile(r * width + c, total);
				end
			end
			res.tile   = in_map ? grid[idx] : 8'd0;
			res.in_map = in_map;
			pending.insert(pending.size(), res);
		endfunction

		function void report(string msg);
			$display("mismatch: %s", msg);
			errors++;
		endfunction

		function void check_result(logic [7:0] tile, logic in_map);
			tile_result_t exp_res;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result tile=%0d ok=%0b", tile, in_map));
				return;
			end
			exp_res = pending.pop_front();
			if (tile !== exp_res.tile)
				report($sformatf("tile_out %0d, want %0d", tile, exp_res.tile));
			if (in_map !== exp_res.in_map)
				report($sformatf("ok %0b, want %0b", in_map, exp_res.in_map));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  op;
	logic [11:0] x_pos;
	logic [11:0] y_pos;
	logic [7:0]  tile_in;
	logic        done;
	logic [7:0]  tile_out;
	logic        ok;
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [12:0] cfg_wdata;

	tile_map_mirror mirror = new();
	int             cycles = 0;
	bit             calm   = 0;

	tile_map_autotile_core dut (.*);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// results cannot be held off: check each one as it appears
	always @(posedge clk)
		if (arst_n && done) mirror.check_result(tile_out, ok);

	// issue one item; start stays high across back-to-back items unless a random gap drops it
	task automatic send_item(logic [1:0] o, logic [11:0] x, logic [11:0] y, logic [7:0] t);
		if (!calm && $urandom_range(99) < 6) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		start   <= 1'b1;
		op      <= o;
		x_pos   <= x;
		y_pos   <= y;
		tile_in <= t;
		do @(posedge clk); while (busy);
		mirror.note_item(o, x, y, t);
	endtask

	// stop sending until every expected result is back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (mirror.pending.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [12:0] val);
		drain();
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror.set_reg(idx, val);
	endtask

	task automatic set_map(int w, int h, logic [1:0] m);
		write_reg(tma_pkg::CFG_WIDTH, 13'(w));
		write_reg(tma_pkg::CFG_HEIGHT, 13'(h));
		write_reg(tma_pkg::CFG_MODE, 13'(m));
	endtask

	// mostly in-map writes with filled tiles so regions form; some noise
	task automatic random_items(int n);
		int unsigned nrows, total;
		logic [1:0]  o;
		logic [11:0] x, y;
		logic [7:0]  t;
		int          pick;
		nrows = mirror.rows();
		total = mirror.width * nrows;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 20) o = tma_pkg::OP_READ;
			else if (pick < 50) o = tma_pkg::OP_WRITE;
			else if (pick < 95) o = tma_pkg::OP_WRITE_NBR;
			else o = (total <= 128) ? tma_pkg::OP_MAP : tma_pkg::OP_WRITE_NBR;
			if (nrows == 0 || $urandom_range(99) < 10) begin
				x = 12'($urandom);
				y = 12'($urandom);
			end else begin
				x = 12'($urandom_range(mirror.width > 4095 ? 4095 : mirror.width));
				y = 12'($urandom_range(nrows));
				if (x >= mirror.width) x = 12'($urandom_range(mirror.width - 1));
			end
			t = ($urandom_range(99) < 30) ? 8'd0 : 8'($urandom);
			send_item(o, x, y, t);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		op        = tma_pkg::OP_READ;
		x_pos     = '0;
		y_pos     = '0;
		tile_in   = '0;
		cfg_we    = 1'b0;
		cfg_idx   = tma_pkg::CFG_WIDTH;
		cfg_wdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset map, mode off
		send_item(tma_pkg::OP_READ, 12'd0, 12'd0, 8'd0);
		send_item(tma_pkg::OP_WRITE, 12'd63, 12'd63, 8'd255);
		send_item(tma_pkg::OP_READ, 12'd63, 12'd63, 8'd0);
		send_item(tma_pkg::OP_WRITE, 12'd64, 12'd0, 8'd7);
		send_item(tma_pkg::OP_READ, 12'd4095, 12'd4095, 8'd0);
		send_item(tma_pkg::OP_WRITE_NBR, 12'd0, 12'd63, 8'd170);
		send_item(tma_pkg::OP_MAP, 12'd4095, 12'd0, 8'd0);
		send_item(tma_pkg::OP_MAP, 12'd63, 12'd63, 8'd0);

		// four-neighbor on a full 64x64 map, one whole-map pass
		write_reg(tma_pkg::CFG_MODE, 13'd1);
		send_item(tma_pkg::OP_WRITE_NBR, 12'd62, 12'd63, 8'd85);
		send_item(tma_pkg::OP_WRITE_NBR, 12'd0, 12'd0, 8'd1);
		send_item(tma_pkg::OP_MAP, 12'd100, 12'd100, 8'd0);

		// alternate mode on a solid 3x3, then holes at two corners: interior corners
		set_map(3, 3, tma_pkg::MODE_ALT);
		for (int i = 0; i < 9; i++)
			send_item(tma_pkg::OP_WRITE, 12'(i % 3), 12'(i / 3), 8'd9);
		send_item(tma_pkg::OP_WRITE_NBR, 12'd0, 12'd0, 8'd0);
		send_item(tma_pkg::OP_MAP, 12'd1, 12'd1, 8'd0);
		send_item(tma_pkg::OP_WRITE_NBR, 12'd2, 12'd2, 8'd0);
		send_item(tma_pkg::OP_READ, 12'd3, 12'd0, 8'd0);
		drain();

		// random phases over a spread of settings
		set_map(4, 4, 2'd1);               random_items(80);
		set_map(8, 8, tma_pkg::MODE_ALT);  random_items(100);
		calm = 1;
		set_map(5, 3, tma_pkg::MODE_ALT);  random_items(100);
		calm = 0;
		set_map(1, 1, 2'd1);               random_items(20);
		set_map(1, 16, tma_pkg::MODE_ALT); random_items(40);
		set_map(16, 1, 2'd3);              random_items(40);
		set_map(7, 9, tma_pkg::MODE_OFF);  random_items(50);
		set_map(3, 5, tma_pkg::MODE_ALT);  random_items(80);
		drain();
		set_map(2, 2, tma_pkg::MODE_ALT);  random_items(40);
		set_map(6, 6, 2'd3);               random_items(60);

		// extremes: widest map, empty maps, tall map clipped to the store
		set_map(4096, 1, tma_pkg::MODE_ALT);
		random_items(30);
		send_item(tma_pkg::OP_MAP, 12'd4095, 12'd0, 8'd0);
		set_map(8191, 4, 2'd1);            random_items(15);
		set_map(0, 4, 2'd1);               random_items(15);
		set_map(4, 0, tma_pkg::MODE_ALT);  random_items(15);
		set_map(64, 8191, 2'd1);
		random_items(20);
		send_item(tma_pkg::OP_WRITE_NBR, 12'd63, 12'd63, 8'd3);
		send_item(tma_pkg::OP_READ, 12'd0, 12'd64, 8'd0);
		set_map(4096, 4096, 2'd1);         random_items(10);
		set_map(4, 4, tma_pkg::MODE_ALT);  random_items(60);

		drain();
		repeat (20) @(posedge clk);
		if (mirror.pending.size() != 0)
			mirror.report($sformatf("%0d results never came", mirror.pending.size()));
		if (mirror.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
